### src/aesc_pkg.sv
// Shared types, constants and AES round functions for the CTR byte cipher.
// Used by the top level, core, queue and front end; depends on nothing else.
package aesc_pkg;

  localparam int BLK_W   = 128;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 4;
  localparam int RND_W   = 4;
  localparam int CFG_W   = 64;
  localparam int IDX_W   = 2;
  localparam logic [RND_W-1:0] LAST_RND = 4'd10;

  typedef enum logic [IDX_W-1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_NONCE    = 2'd2,
    REG_NONE     = 2'd3
  } cfg_reg_t;

  // head of the keystream queue as the front end sees it
  typedef struct packed {
    logic             valid;
    logic [BLK_W-1:0] blk;
  } ks_head_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon_of(input logic [RND_W-1:0] rnd);
    logic [7:0] rc;
    unique case (rnd)
      4'd1:    rc = 8'h01;
      4'd2:    rc = 8'h02;
      4'd3:    rc = 8'h04;
      4'd4:    rc = 8'h08;
      4'd5:    rc = 8'h10;
      4'd6:    rc = 8'h20;
      4'd7:    rc = 8'h40;
      4'd8:    rc = 8'h80;
      4'd9:    rc = 8'h1b;
      4'd10:   rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  // next round key from the previous one; byte 0 sits in bits [127:120]
  function automatic logic [BLK_W-1:0] key_next(input logic [BLK_W-1:0] rk,
                                                input logic [7:0] rc);
    logic [31:0] tmp, w0, w1, w2, w3;
    tmp = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    w0  = rk[127:96] ^ tmp;
    w1  = rk[95:64] ^ w0;
    w2  = rk[63:32] ^ w1;
    w3  = rk[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows, MixColumns (skipped on the last round), AddRoundKey
  function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s,
                                                 input logic [BLK_W-1:0] rk,
                                                 input logic last);
    logic [7:0]       t [16];
    logic [7:0]       a0, a1, a2, a3, x;
    logic [BLK_W-1:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[c*4+i] = SBOX[s[127 - 8*((((c+i) % 4) * 4) + i) -: 8]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4];
        a1 = t[c*4+1];
        a2 = t[c*4+2];
        a3 = t[c*4+3];
        x  = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]   = a0 ^ x ^ xtime(a0 ^ a1);
        t[c*4+1] = a1 ^ x ^ xtime(a1 ^ a2);
        t[c*4+2] = a2 ^ x ^ xtime(a2 ^ a3);
        t[c*4+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127 - 8*i -: 8] = t[i] ^ rk[127 - 8*i -: 8];
    end
    return r;
  endfunction

endpackage

### src/aes128_ctr_byte_cipher.sv
// Top level of the AES-128 counter mode byte cipher.
// Depends on aesc_pkg, aesc_core, aesc_ksq and aesc_front.
//
// Input words (in_data_byte) enter on in_valid/in_stall, results leave on
// out_valid/out_stall as out_byte = in_data_byte XOR next keystream byte.
// A result shows in the output register the cycle after its word is taken,
// and a new word is taken every cycle unless the keystream or output stalls.
// The AES core makes each 16-byte block by a load, ten rounds and a step to
// hand the block over, and writes into a two-block queue, so while the output
// is not stalled the sustained rate is one word per cycle.
// The first word of a stream waits for its first block.
// While out_stall is high and a result waits, in_stall is high too.
// Configuration: cfg_we, cfg_index, cfg_wdata; index 0 key high, 1 key low,
// 2 nonce. A nonce write restarts the stream with counter {nonce, 0}; a key
// write keeps the block in use and drops blocks made ahead with the old key.
// Write configuration only while no word is in flight.
// Synchronous active-low reset clears key, nonce, counter and position.
module aes128_ctr_byte_cipher (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [aesc_pkg::BYTE_W-1:0] in_data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [aesc_pkg::BYTE_W-1:0] out_byte,
  input  logic                        cfg_we,
  input  logic [aesc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [aesc_pkg::CFG_W-1:0]  cfg_wdata
);

  logic [aesc_pkg::CFG_W-1:0] key_hi_r, key_hi_nxt, key_lo_r, key_lo_nxt;
  logic [aesc_pkg::BLK_W-1:0] ctr_r, ctr_nxt, gctr_r, gctr_nxt;
  aesc_pkg::cfg_reg_t         idx;
  logic                       flush, restart, start, busy, done, pop;
  logic [aesc_pkg::BLK_W-1:0] core_blk;
  logic [1:0]                 qcnt;
  aesc_pkg::ks_head_t         head;

  assign idx     = aesc_pkg::cfg_reg_t'(cfg_index);
  assign restart = cfg_we && (idx == aesc_pkg::REG_NONCE);
  assign flush   = cfg_we && (idx != aesc_pkg::REG_NONE);
  assign start   = !flush && !busy && (qcnt != 2'd2);

  always_comb begin
    key_hi_nxt = key_hi_r;
    key_lo_nxt = key_lo_r;
    ctr_nxt    = ctr_r;
    gctr_nxt   = gctr_r;
    if (pop) begin
      ctr_nxt = ctr_r + 128'd1;
    end
    if (start) begin
      gctr_nxt = gctr_r + 128'd1;
    end
    if (cfg_we) begin
      unique case (idx)
        aesc_pkg::REG_KEY_HIGH: begin
          key_hi_nxt = cfg_wdata;
          gctr_nxt   = ctr_r;
        end
        aesc_pkg::REG_KEY_LOW: begin
          key_lo_nxt = cfg_wdata;
          gctr_nxt   = ctr_r;
        end
        aesc_pkg::REG_NONCE: begin
          ctr_nxt  = {cfg_wdata, 64'd0};
          gctr_nxt = {cfg_wdata, 64'd0};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      ctr_r    <= '0;
      gctr_r   <= '0;
    end else begin
      key_hi_r <= key_hi_nxt;
      key_lo_r <= key_lo_nxt;
      ctr_r    <= ctr_nxt;
      gctr_r   <= gctr_nxt;
    end
  end

  aesc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .abort (flush),
    .key   ({key_hi_r, key_lo_r}),
    .ctr   (gctr_r),
    .busy  (busy),
    .done  (done),
    .blk   (core_blk)
  );

  aesc_ksq u_ksq (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (flush),
    .push     (done),
    .push_blk (core_blk),
    .pop      (pop),
    .count    (qcnt),
    .head     (head)
  );

  aesc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (restart),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .head         (head),
    .pop          (pop)
  );

endmodule

### src/aesc_core.sv
// Iterative AES-128 encryption core: one round and one key expansion step
// per cycle. Depends on aesc_pkg.
module aesc_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      abort,
  input  logic [aesc_pkg::BLK_W-1:0] key,
  input  logic [aesc_pkg::BLK_W-1:0] ctr,
  output logic                      busy,
  output logic                      done,
  output logic [aesc_pkg::BLK_W-1:0] blk
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [aesc_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  logic [aesc_pkg::BLK_W-1:0] st_r, st_nxt;
  logic [aesc_pkg::BLK_W-1:0] rk_r, rk_nxt;
  logic [aesc_pkg::BLK_W-1:0] rk_step;

  assign rk_step = aesc_pkg::key_next(rk_r, aesc_pkg::rcon_of(rnd_r));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rnd_nxt  = rnd_r;
    st_nxt   = st_r;
    rk_nxt   = rk_r;
    if (abort) begin
      busy_nxt = 1'b0;
    end else if (start) begin
      busy_nxt = 1'b1;
      rnd_nxt  = 4'd1;
      st_nxt   = ctr ^ key;
      rk_nxt   = key;
    end else if (busy_r) begin
      rk_nxt  = rk_step;
      st_nxt  = aesc_pkg::aes_round(st_r, rk_step, rnd_r == aesc_pkg::LAST_RND);
      rnd_nxt = rnd_r + 4'd1;
      if (rnd_r == aesc_pkg::LAST_RND) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      rnd_r  <= rnd_nxt;
    end
    st_r <= st_nxt;
    rk_r <= rk_nxt;
  end

  // the done cycle still counts as busy so the queue never overfills
  assign busy = busy_r | done_r;
  assign done = done_r;
  assign blk  = st_r;

endmodule

### src/aesc_ksq.sv
// Two-entry queue of keystream blocks between the AES core and the front end.
// Depends on aesc_pkg.
module aesc_ksq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       flush,
  input  logic                       push,
  input  logic [aesc_pkg::BLK_W-1:0] push_blk,
  input  logic                       pop,
  output logic [1:0]                 count,
  output aesc_pkg::ks_head_t         head
);

  logic [1:0]                 cnt_r, cnt_nxt;
  logic [aesc_pkg::BLK_W-1:0] e0_r, e0_nxt, e1_r, e1_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    if (flush) begin
      cnt_nxt = 2'd0;
    end else begin
      if (pop) begin
        e0_nxt  = e1_r;
        cnt_nxt = cnt_nxt - 2'd1;
      end
      if (push) begin
        // land behind whatever remains after the pop
        if (cnt_nxt == 2'd0) begin
          e0_nxt = push_blk;
        end else begin
          e1_nxt = push_blk;
        end
        cnt_nxt = cnt_nxt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  assign count      = cnt_r;
  assign head.valid = cnt_r != 2'd0;
  assign head.blk   = e0_r;

endmodule

### src/aesc_front.sv
// Front end: takes input words, picks the keystream byte and XORs it in,
// holds the result in an output register. Depends on aesc_pkg.
module aesc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        restart,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [aesc_pkg::BYTE_W-1:0] in_data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [aesc_pkg::BYTE_W-1:0] out_byte,
  input  aesc_pkg::ks_head_t          head,
  output logic                        pop
);

  logic [aesc_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [aesc_pkg::BLK_W-1:0]  cur_r, cur_nxt;
  logic                        ov_r, ov_nxt;
  logic [aesc_pkg::BYTE_W-1:0] ob_r, ob_nxt;
  logic [6:0]                  lsb;
  logic [aesc_pkg::BYTE_W-1:0] ks_byte;
  logic                        room, have_ks, acc;

  assign lsb     = 7'd120 - {pos_r, 3'b000};
  assign ks_byte = (pos_r == '0) ? head.blk[127:120] : cur_r[lsb +: 8];
  assign room    = !ov_r || !out_stall;
  assign have_ks = (pos_r != '0) || head.valid;
  assign acc     = in_valid && room && have_ks;
  assign in_stall = !(room && have_ks);
  assign pop     = acc && (pos_r == '0);

  always_comb begin
    pos_nxt = pos_r;
    cur_nxt = cur_r;
    ov_nxt  = ov_r;
    ob_nxt  = ob_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    if (acc) begin
      ov_nxt  = 1'b1;
      ob_nxt  = in_data_byte ^ ks_byte;
      pos_nxt = pos_r + 4'd1;
      if (pos_r == '0) begin
        cur_nxt = head.blk;
      end
    end
    // fresh stream: next word opens a new block
    if (restart) begin
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      ov_r  <= ov_nxt;
    end
    cur_r <= cur_nxt;
    ob_r  <= ob_nxt;
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;

endmodule

### src/aesc_checker.sv
// Port-level checks for the AES-128 CTR byte cipher, bound to the top level.
// Depends on aes128_ctr_byte_cipher's ports only.
module aesc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte
);

  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present right after reset");

  a_accept_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word gave no result");

  a_full_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("word taken while result register is held");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled result changed");

endmodule

bind aes128_ctr_byte_cipher aesc_checker u_aesc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte)
);
